FILE: rtl/olafb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olafb_pkg
// Shared types and constants of the overlap-add fractional buffer: field
// widths, controller states, command and status bundles, register map.
// ----------------------------------------------------------------------------
package olafb_pkg;

    // Defaults for the top-level parameters
    localparam int RING_DEPTH_DEF = 16384;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 20;
    localparam int ACC_W      = 24;
    localparam int LOC_W      = 24;
    localparam int TIME_W     = 40;
    localparam int CUR_TIME_W = 32;
    localparam int FIDX_W     = 14;
    localparam int THR_W      = 16;

    // Weighted sample: a convex blend of two Q1.15 values, one guard bit
    localparam int WV_W       = SAMPLE_W + 1;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic CFG_FILL_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] FILL_THRESHOLD_RST = THR_W'(4096);

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_WR1,
        S_RD2,
        S_WR2,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // zero one ring entry (clearing pass)
        logic accept;  // capture the input transaction
        logic rd;      // issue ring read, register weighted value
        logic wr;      // write back saturated sum (or zero on pop)
        logic second;  // second read-modify-write of a closing frame sample
        logic commit;  // update scalar state and load result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic started;     // a frame sample is held awaiting its successor
        logic clear_last;  // clearing pass is on the final entry
    } t_status;

endpackage : olafb_pkg
`default_nettype wire

FILE: rtl/olafb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olafb_dp
// Datapath: ring accumulator memory, frame/location/time state, fractional
// weighting, saturating accumulate and the result register.
// ----------------------------------------------------------------------------
module olafb_dp #(
    parameter int RING_DEPTH = olafb_pkg::RING_DEPTH_DEF,
    parameter int FRAC_BITS  = olafb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire olafb_pkg::t_cmd                        i_cmd,
    output      olafb_pkg::t_status                     o_status,
    input  wire logic                                   i_func,
    input  wire logic signed [olafb_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                   i_last_of_frame,
    input  wire logic [olafb_pkg::PERIOD_W-1:0]         i_period,
    input  wire logic [olafb_pkg::THR_W-1:0]            i_fill_threshold,
    output      logic signed [olafb_pkg::ACC_W-1:0]     o_out_sample,
    output      logic                                   o_filled,
    output      logic [olafb_pkg::CUR_TIME_W-1:0]       o_current_time,
    output      logic                                   o_underrun
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int SW   = olafb_pkg::SAMPLE_W;
    localparam int AccW = olafb_pkg::ACC_W;
    localparam int LocW = olafb_pkg::LOC_W;
    localparam int TmW  = olafb_pkg::TIME_W;
    localparam int FiW  = olafb_pkg::FIDX_W;
    localparam int WvW  = olafb_pkg::WV_W;
    // blend product width: 17-bit difference times (FRAC_BITS+1)-bit weight
    localparam int TW   = WvW + FRAC_BITS + 2;
    // compare width for the fill test
    localparam int CW   = (LocW > olafb_pkg::THR_W + FRAC_BITS) ?
                          LocW : olafb_pkg::THR_W + FRAC_BITS;
    localparam logic signed [TW-1:0] HALF    = TW'(1) << (FRAC_BITS - 1);
    localparam logic [LocW-1:0]      ONE_LOC = LocW'(1) << FRAC_BITS;

    // Captured transaction
    logic                    r_func;
    logic signed [SW-1:0]    r_sample;
    logic                    r_last;
    logic [olafb_pkg::PERIOD_W-1:0] r_period;

    // Scalar state
    logic [AW-1:0]           r_head, n_head;
    logic [LocW-1:0]         r_loc, n_loc;
    logic [TmW-1:0]          r_time, n_time;
    logic signed [SW-1:0]    r_held, n_held;
    logic [FiW-1:0]          r_fi, n_fi;
    logic [FRAC_BITS-1:0]    r_frac;
    logic                    r_started, n_started;
    logic                    n_under;

    // Memory access
    logic [AW-1:0]           r_clr;
    logic [AW-1:0]           r_addr;
    logic signed [WvW-1:0]   r_v;
    logic signed [AccW-1:0]  r_rdata;
    logic signed [AccW-1:0]  r_popped;
    logic signed [AccW-1:0]  mem [RING_DEPTH];

    logic [FiW-1:0]          rd_off;
    logic [AW-1:0]           rd_addr;
    logic signed [SW-1:0]    s_cur, s_nxt;
    logic signed [WvW-1:0]   s_diff;
    logic signed [TW-1:0]    blend, blend_shr;
    logic signed [AccW:0]    acc_sum;
    logic signed [AccW-1:0]  acc_sat;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic signed [AccW-1:0]  mem_wd;
    logic [LocW:0]           loc_adv;

    assign o_status.started    = r_started;
    assign o_status.clear_last = (r_clr == AW'(RING_DEPTH - 1));

    // Transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= i_func;
            r_sample <= i_sample;
            r_last   <= i_last_of_frame;
            r_period <= i_period;
        end
    end

    // Read address: head, plus integer location and frame index for an add
    always_comb begin
        rd_off = '0;
        if (!r_func && r_started) begin
            rd_off = r_fi + FiW'(i_cmd.second);
        end
        if (r_func) begin
            rd_addr = r_head;
        end else begin
            rd_addr = r_head + AW'(r_loc >> FRAC_BITS) + AW'(rd_off);
        end
    end

    // Blend operands: held/current pair, closing sample with itself,
    // or a lone sample against zero
    always_comb begin
        if (i_cmd.second) begin
            s_cur = r_sample;
            s_nxt = r_sample;
        end else if (!r_started) begin
            s_cur = r_sample;
            s_nxt = '0;
        end else begin
            s_cur = r_held;
            s_nxt = r_sample;
        end
        // s*a + n*(1-a) == n*1 + (s-n)*a, round half up
        s_diff    = WvW'(s_cur) - WvW'(s_nxt);
        blend     = (TW'(s_nxt) <<< FRAC_BITS)
                  + TW'(s_diff) * TW'($signed({1'b0, r_frac}))
                  + HALF;
        blend_shr = blend >>> FRAC_BITS;
    end

    // Saturating accumulate
    always_comb begin
        acc_sum = (AccW + 1)'(r_rdata) + (AccW + 1)'(r_v);
        if (acc_sum[AccW] != acc_sum[AccW-1]) begin
            acc_sat = acc_sum[AccW] ? {1'b1, {(AccW - 1){1'b0}}}
                                    : {1'b0, {(AccW - 1){1'b1}}};
        end else begin
            acc_sat = acc_sum[AccW-1:0];
        end
    end

    // Memory write port: clearing pass or write-back
    always_comb begin
        mem_we = i_cmd.clear || i_cmd.wr;
        mem_wa = i_cmd.clear ? r_clr : r_addr;
        mem_wd = (i_cmd.clear || r_func) ? '0 : acc_sat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    // Read stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_addr <= rd_addr;
            r_v    <= WvW'(blend_shr);
        end
        if (i_cmd.wr && r_func) begin
            r_popped <= r_rdata;
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Next scalar state at commit
    always_comb begin
        n_head    = r_head;
        n_loc     = r_loc;
        n_time    = r_time;
        n_held    = r_held;
        n_fi      = r_fi;
        n_started = r_started;
        n_under   = 1'b0;
        loc_adv   = {1'b0, r_loc} + (LocW + 1)'(r_period);
        if (r_func) begin
            n_head = r_head + AW'(1);
            // below one sample: clamp at zero and flag
            if ((r_loc >> FRAC_BITS) == '0) begin
                n_loc   = '0;
                n_under = 1'b1;
            end else begin
                n_loc = r_loc - ONE_LOC;
            end
        end else begin
            if (r_last) begin
                n_loc     = loc_adv[LocW] ? '1 : loc_adv[LocW-1:0];
                n_time    = r_time + TmW'(r_period);
                n_started = 1'b0;
                n_fi      = '0;
            end else begin
                n_held    = r_sample;
                n_started = 1'b1;
                if (r_started) begin
                    n_fi = r_fi + FiW'(1);
                end
            end
        end
    end

    // Scalar state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_loc     <= '0;
            r_time    <= '0;
            r_held    <= '0;
            r_fi      <= '0;
            r_frac    <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.accept) begin
            // a new frame latches its fraction
            if (!i_func && !r_started) begin
                r_frac <= r_loc[FRAC_BITS-1:0];
                r_fi   <= '0;
            end
        end else if (i_cmd.commit) begin
            r_head    <= n_head;
            r_loc     <= n_loc;
            r_time    <= n_time;
            r_held    <= n_held;
            r_fi      <= n_fi;
            r_started <= n_started;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_sample   <= r_func ? r_popped : '0;
            o_filled       <= CW'(n_loc) > (CW'(i_fill_threshold) << FRAC_BITS);
            o_current_time <= olafb_pkg::CUR_TIME_W'(n_time >> FRAC_BITS);
            o_underrun     <= n_under;
        end
    end

endmodule : olafb_dp
`default_nettype wire

FILE: rtl/olafb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olafb_ctrl
// Controller: sequences the clearing pass, transaction capture, up to two
// ring read-modify-writes and the result handoff.
// ----------------------------------------------------------------------------
module olafb_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_func,
    input  wire logic                i_last_of_frame,
    input  wire logic                i_out_ready,
    input  wire olafb_pkg::t_status  i_status,
    output      logic                o_in_ready,
    output      logic                o_out_valid,
    output      olafb_pkg::t_cmd     o_cmd
);

    olafb_pkg::t_state r_state, n_state;
    logic              r_two, n_two;
    logic              r_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olafb_pkg::S_CLEAR;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_two   <= n_two;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_two      = r_two;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            olafb_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = olafb_pkg::S_IDLE;
                end
            end
            olafb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_two = !i_func && i_status.started && i_last_of_frame;
                    // only the opening sample of a longer frame skips the ring
                    if (i_func || i_status.started || i_last_of_frame) begin
                        n_state = olafb_pkg::S_RD1;
                    end else begin
                        n_state = olafb_pkg::S_FIN;
                    end
                end
            end
            olafb_pkg::S_RD1: begin
                o_cmd.rd = 1'b1;
                n_state  = olafb_pkg::S_WR1;
            end
            olafb_pkg::S_WR1: begin
                o_cmd.wr = 1'b1;
                n_state  = r_two ? olafb_pkg::S_RD2 : olafb_pkg::S_FIN;
            end
            olafb_pkg::S_RD2: begin
                o_cmd.rd     = 1'b1;
                o_cmd.second = 1'b1;
                n_state      = olafb_pkg::S_WR2;
            end
            olafb_pkg::S_WR2: begin
                o_cmd.wr     = 1'b1;
                o_cmd.second = 1'b1;
                n_state      = olafb_pkg::S_FIN;
            end
            olafb_pkg::S_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = olafb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olafb_pkg::S_CLEAR;
            end
        endcase
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    // an accepted transaction always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != olafb_pkg::S_IDLE))
        else $error("accepted transaction did not start");

    // write-back always follows its read
    a_wr1_after_rd1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olafb_pkg::S_WR1) |-> $past(r_state == olafb_pkg::S_RD1))
        else $error("write-back without read");

    // second read-modify-write only for a closing sample of a running frame
    a_second_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olafb_pkg::S_RD2) |-> (r_two && $past(r_state == olafb_pkg::S_WR1)))
        else $error("unexpected second read-modify-write");

    // a result appears only from the finish state
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == olafb_pkg::S_FIN))
        else $error("result raised outside finish");
`endif

endmodule : olafb_ctrl
`default_nettype wire

FILE: rtl/overlap_add_fractional_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_add_fractional_buffer_unit
// Overlap-add ring accumulator with linear fractional delay: top level with
// the APB register, controller and datapath.
// ----------------------------------------------------------------------------
// After reset the ring memory is swept to zero, one entry per cycle, over
// all RING_DEPTH entries; no transaction is accepted during that pass, APB
// writes are taken throughout. RING_DEPTH must be a power of two. Each
// transaction gives exactly one result. The opening sample of a multi-sample
// frame is only captured and committed, a pop or any other add makes one ring
// update, the closing sample of a running frame two: each ring update is a
// read-modify-write on the single-port-per-direction ring memory (a read,
// then a write-back) between the capture and result steps. The result
// register lets a finished result wait while the next transaction is taken.
// ----------------------------------------------------------------------------
module overlap_add_fractional_buffer_unit #(
    parameter int RING_DEPTH = olafb_pkg::RING_DEPTH_DEF,
    parameter int FRAC_BITS  = olafb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // input channel
    input  wire logic                                     i_in_valid,
    output      logic                                     o_in_ready,
    input  wire logic                                     i_func,
    input  wire logic signed [olafb_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire logic                                     i_last_of_frame,
    input  wire logic [olafb_pkg::PERIOD_W-1:0]           i_period,
    // output channel
    output      logic                                     o_out_valid,
    input  wire logic                                     i_out_ready,
    output      logic signed [olafb_pkg::ACC_W-1:0]       o_out_sample,
    output      logic                                     o_filled,
    output      logic [olafb_pkg::CUR_TIME_W-1:0]         o_current_time,
    output      logic                                     o_underrun,
    // APB configuration
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [olafb_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire logic [olafb_pkg::APB_DATA_W-1:0]         pwdata,
    output      logic [olafb_pkg::APB_DATA_W-1:0]         prdata,
    output      logic                                     pready
);

    olafb_pkg::t_cmd    cmd;
    olafb_pkg::t_status status;
    logic [olafb_pkg::THR_W-1:0] r_fill_threshold;
    logic                        reg_idx;

    // Register index from the word address
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    // Fill threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_threshold <= olafb_pkg::FILL_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready &&
                     reg_idx == olafb_pkg::CFG_FILL_THRESHOLD) begin
            r_fill_threshold <= pwdata[olafb_pkg::THR_W-1:0];
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        if (reg_idx == olafb_pkg::CFG_FILL_THRESHOLD) begin
            prdata = olafb_pkg::APB_DATA_W'(r_fill_threshold);
        end
    end

    olafb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_func          (i_func),
        .i_last_of_frame (i_last_of_frame),
        .i_out_ready     (i_out_ready),
        .i_status        (status),
        .o_in_ready      (o_in_ready),
        .o_out_valid     (o_out_valid),
        .o_cmd           (cmd)
    );

    olafb_dp #(
        .RING_DEPTH (RING_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_func           (i_func),
        .i_sample         (i_sample),
        .i_last_of_frame  (i_last_of_frame),
        .i_period         (i_period),
        .i_fill_threshold (r_fill_threshold),
        .o_out_sample     (o_out_sample),
        .o_filled         (o_filled),
        .o_current_time   (o_current_time),
        .o_underrun       (o_underrun)
    );

endmodule : overlap_add_fractional_buffer_unit
`default_nettype wire

FILE: tb/olafb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olafb_checker
// Watches the input, output and register channels of the overlap-add
// fractional buffer. Runs its own copy of the ring and frame state for every
// accepted input transaction, queues the result that the block should give,
// and compares each accepted output transaction field by field with the
// oldest queued result.
// ----------------------------------------------------------------------------
module olafb_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_in_valid,
    input  wire logic                                  i_in_ready,
    input  wire logic                                  i_func,
    input  wire logic signed [olafb_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                  i_last_of_frame,
    input  wire logic [olafb_pkg::PERIOD_W-1:0]        i_period,
    // output channel
    input  wire logic                                  i_out_valid,
    input  wire logic                                  i_out_ready,
    input  wire logic signed [olafb_pkg::ACC_W-1:0]    i_out_sample,
    input  wire logic                                  i_filled,
    input  wire logic [olafb_pkg::CUR_TIME_W-1:0]      i_current_time,
    input  wire logic                                  i_underrun,
    // register port
    input  wire logic                                  i_psel,
    input  wire logic                                  i_penable,
    input  wire logic                                  i_pwrite,
    input  wire logic [olafb_pkg::APB_ADDR_W-1:0]      i_paddr,
    input  wire logic [olafb_pkg::APB_DATA_W-1:0]      i_pwdata,
    input  wire logic                                  i_pready,
    // to the test top
    output int                                         o_mismatches,
    output int                                         o_pending
);
    import olafb_pkg::*;

    localparam int RING_DEPTH = RING_DEPTH_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int ACC_MAX    = (1 << (ACC_W - 1)) - 1;
    localparam int ACC_MIN    = -(1 << (ACC_W - 1));
    localparam longint UNIT   = longint'(1) << FRAC_BITS;
    localparam logic [LOC_W-1:0] UNIT_LOC = LOC_W'(1) << FRAC_BITS;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR =
        APB_ADDR_W'(4 * int'(CFG_FILL_THRESHOLD));

    typedef struct packed {
        logic signed [ACC_W-1:0] smp;
        logic                    filled;
        logic [CUR_TIME_W-1:0]   now;
        logic                    underrun;
    } t_result;

    // Own copy of the buffer state
    logic signed [ACC_W-1:0]    mix_ring [RING_DEPTH];
    int                         read_ptr;
    logic [LOC_W-1:0]           lead;
    logic [TIME_W-1:0]          elapsed;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic [FIDX_W-1:0]          slot_ofs;
    logic [FRAC_BITS-1:0]       grain_frac;
    logic                       in_frame;
    logic [THR_W-1:0]           thr_samples;

    t_result                    due_results [$];
    t_result                    oldest;
    int                         mismatches;

    // Linear blend of two neighbouring samples, rounded half up
    function automatic int blend_pair(input int cur, input int nxt);
        longint acc;
        acc = longint'(cur) * longint'(grain_frac)
            + longint'(nxt) * (UNIT - longint'(grain_frac))
            + (UNIT >>> 1);
        return int'(acc >>> FRAC_BITS);
    endfunction

    // Saturating add into the ring, relative to head plus integer lead
    function automatic void accumulate_slot(input int ofs, input int v);
        int addr;
        int sum;
        addr = (read_ptr + int'(lead >> FRAC_BITS) + ofs) % RING_DEPTH;
        sum  = int'(mix_ring[addr]) + v;
        if (sum > ACC_MAX) sum = ACC_MAX;
        if (sum < ACC_MIN) sum = ACC_MIN;
        mix_ring[addr] = ACC_W'(sum);
    endfunction

    // Frame hop: lead saturates, time wraps
    function automatic void hop_forward(input logic [PERIOD_W-1:0] per);
        logic [LOC_W:0] wide;
        wide = {1'b0, lead} + (LOC_W + 1)'(per);
        lead = wide[LOC_W] ? '1 : wide[LOC_W-1:0];
        elapsed = elapsed + TIME_W'(per);
    endfunction

    // One input transaction: update the state, return its result
    function automatic t_result apply_item(
        input logic                       func,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       last,
        input logic [PERIOD_W-1:0]        per
    );
        t_result res;
        res = '0;
        if (func) begin
            // pop: hand out the head slot and clear it
            res.smp = mix_ring[read_ptr];
            mix_ring[read_ptr] = '0;
            read_ptr = (read_ptr + 1) % RING_DEPTH;
            if (lead < UNIT_LOC) begin
                lead = '0;
                res.underrun = 1'b1;
            end else begin
                lead = lead - UNIT_LOC;
            end
        end else if (!in_frame) begin
            // opening sample latches the fraction
            grain_frac = lead[FRAC_BITS-1:0];
            slot_ofs   = '0;
            if (last) begin
                accumulate_slot(0, blend_pair(int'(smp), 0));
                hop_forward(per);
            end else begin
                prev_sample = smp;
                in_frame    = 1'b1;
            end
        end else begin
            accumulate_slot(int'(slot_ofs), blend_pair(int'(prev_sample), int'(smp)));
            slot_ofs = slot_ofs + 1'b1;
            if (last) begin
                // closing sample pairs with itself
                accumulate_slot(int'(slot_ofs), blend_pair(int'(smp), int'(smp)));
                hop_forward(per);
                in_frame = 1'b0;
                slot_ofs = '0;
            end else begin
                prev_sample = smp;
            end
        end
        res.filled = (32'(lead) > (32'(thr_samples) << FRAC_BITS));
        res.now    = elapsed[FRAC_BITS +: CUR_TIME_W];
        return res;
    endfunction

    // Prediction on input, comparison on output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < RING_DEPTH; a++) mix_ring[a] = '0;
            read_ptr    = 0;
            lead        = '0;
            elapsed     = '0;
            prev_sample = '0;
            slot_ofs    = '0;
            grain_frac  = '0;
            in_frame    = 1'b0;
            thr_samples = FILL_THRESHOLD_RST;
            mismatches  = 0;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == THR_ADDR)
                thr_samples = i_pwdata[THR_W-1:0];

            if (i_in_valid && i_in_ready)
                due_results.push_back(apply_item(i_func, i_sample, i_last_of_frame,
                                                 i_period));

            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result transaction with nothing outstanding", $time);
                    mismatches++;
                end else begin
                    oldest = due_results.pop_front();
                    if (i_out_sample !== oldest.smp) begin
                        $display("%0t: out_sample expected %0d, got %0d",
                                 $time, oldest.smp, i_out_sample);
                        mismatches++;
                    end
                    if (i_filled !== oldest.filled) begin
                        $display("%0t: filled expected %0b, got %0b",
                                 $time, oldest.filled, i_filled);
                        mismatches++;
                    end
                    if (i_current_time !== oldest.now) begin
                        $display("%0t: current_time expected %0d, got %0d",
                                 $time, oldest.now, i_current_time);
                        mismatches++;
                    end
                    if (i_underrun !== oldest.underrun) begin
                        $display("%0t: underrun expected %0b, got %0b",
                                 $time, oldest.underrun, i_underrun);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= due_results.size();
    end

endmodule : olafb_checker

FILE: tb/overlap_add_fractional_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_add_fractional_buffer_unit_test
// Drives the overlap-add fractional buffer with short hand-picked sequences,
// ring saturation pile-ups, random frames interleaved with pops and a final
// run with maximal hops, under random gaps and output stalls. The threshold
// register is rewritten between phases. The checker beside the block does
// the prediction; this module reports the verdict.
// ----------------------------------------------------------------------------
module overlap_add_fractional_buffer_unit_test;
    import olafb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PILE_DEPTH     = 262;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
    localparam logic [PERIOD_W-1:0]        PER_MAX = '1;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR =
        APB_ADDR_W'(4 * int'(CFG_FILL_THRESHOLD));

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_func;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        i_last_of_frame;
    logic [PERIOD_W-1:0]         i_period;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [ACC_W-1:0]     o_out_sample;
    logic                        o_filled;
    logic [CUR_TIME_W-1:0]       o_current_time;
    logic                        o_underrun;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    int   mismatch_count;
    int   results_outstanding;
    int   ready_left;
    logic steady_in;

    overlap_add_fractional_buffer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_sample        (i_sample),
        .i_last_of_frame (i_last_of_frame),
        .i_period        (i_period),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_sample    (o_out_sample),
        .o_filled        (o_filled),
        .o_current_time  (o_current_time),
        .o_underrun      (o_underrun),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    olafb_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_sample        (i_sample),
        .i_last_of_frame (i_last_of_frame),
        .i_period        (i_period),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_sample    (o_out_sample),
        .i_filled        (o_filled),
        .i_current_time  (o_current_time),
        .i_underrun      (o_underrun),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_mismatches    (mismatch_count),
        .o_pending       (results_outstanding)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Output back-pressure: mostly short stalls, a few long, some long open runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_left  <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_left  <= ($urandom_range(0, 99) < 75) ? $urandom_range(0, 2) :
                           ($urandom_range(0, 9) < 8)   ? $urandom_range(3, 10) :
                                                          $urandom_range(20, 80);
        end else begin
            i_out_ready <= 1'b1;
            ready_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) :
                                                          $urandom_range(0, 30);
        end
    end

    // One input transaction, after an optional gap, held until taken
    task automatic send_item(input logic                       func,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic                       last,
                             input logic [PERIOD_W-1:0]        per);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady_in || r < 60) gap = 0;
        else if (r < 90)         gap = $urandom_range(1, 3);
        else if (r < 98)         gap = $urandom_range(4, 10);
        else                     gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= func;
        i_sample        <= smp;
        i_last_of_frame <= last;
        i_period        <= per;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Pop with random content in the ignored fields
    task automatic issue_pop();
        send_item(OP_POP, SAMPLE_W'($urandom), 1'($urandom), PERIOD_W'($urandom));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return SMP_MAX;
        if (r < 24) return SMP_MIN;
        if (r < 30) return '0;
        return SAMPLE_W'($urandom);
    endfunction

    // Random frames with roughly balanced pops, plus loose adds
    task automatic play_frames(input int n);
        int sent;
        int r;
        int len;
        logic [PERIOD_W-1:0] per;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                repeat ($urandom_range(1, 8)) begin
                    issue_pop();
                    sent++;
                end
            end else if (r < 92) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) :
                                                    $urandom_range(1, 6);
                per = ($urandom_range(0, 7) == 0) ? PERIOD_W'($urandom_range(0, 4095)) :
                                                    PERIOD_W'($urandom_range(0, 1535));
                for (int k = 1; k <= len; k++) begin
                    // pops inside a running frame are legal
                    if ($urandom_range(0, 7) == 0) begin
                        issue_pop();
                        sent++;
                    end
                    send_item(OP_ADD, pick_sample(), k == len, per);
                    sent++;
                end
            end else begin
                send_item(OP_ADD, pick_sample(), 1'($urandom),
                          PERIOD_W'($urandom_range(0, 2047)));
                sent++;
            end
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Threshold write: setup then access phase
    task automatic cfg_write(input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        int   w;
        logic leftover;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_func          <= OP_ADD;
        i_sample        <= '0;
        i_last_of_frame <= 1'b0;
        i_period        <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        steady_in        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, one-sample frames, multi-sample frames,
        // extremes, a pop inside a frame, drain into underrun
        issue_pop();
        send_item(OP_ADD, SMP_MAX, 1'b1, 20'h00180);
        send_item(OP_ADD, SMP_MIN, 1'b1, 20'h000FF);
        send_item(OP_ADD, SMP_MAX, 1'b0, 20'h00000);
        send_item(OP_ADD, SMP_MIN, 1'b0, 20'h00000);
        send_item(OP_ADD, SMP_MAX, 1'b1, 20'h00001);
        send_item(OP_ADD, SMP_MIN, 1'b0, 20'h00000);
        send_item(OP_ADD, SMP_MIN, 1'b1, 20'h00000);
        issue_pop();
        send_item(OP_ADD, 16'sd1000, 1'b0, 20'h00000);
        issue_pop();
        send_item(OP_ADD, -16'sd1000, 1'b0, 20'h00000);
        issue_pop();
        send_item(OP_ADD, -16'sd1, 1'b1, 20'h00300);
        send_item(OP_ADD, '0, 1'b1, 20'h0007F);
        repeat (9) issue_pop();
        wait_idle();

        // pile-ups on one slot until the sum saturates, both signs
        cfg_write('0);
        repeat (4) issue_pop();
        send_item(OP_ADD, '0, 1'b1, 20'h000FF);
        repeat (PILE_DEPTH) send_item(OP_ADD, SMP_MAX, 1'b1, '0);
        issue_pop();
        send_item(OP_ADD, '0, 1'b1, 20'h000FF);
        repeat (PILE_DEPTH) send_item(OP_ADD, SMP_MIN, 1'b1, '0);
        issue_pop();
        wait_idle();

        // random frames under a few thresholds
        cfg_write(THR_W'($urandom_range(1, 4)));
        play_frames(250);
        wait_idle();
        cfg_write(THR_W'($urandom));
        play_frames(150);
        wait_idle();
        steady_in = 1'b1;
        cfg_write(THR_W'(1));
        play_frames(150);
        steady_in = 1'b0;
        wait_idle();

        // maximal hops: lead saturates, filled against the top threshold
        cfg_write('1);
        repeat (18) send_item(OP_ADD, pick_sample(), 1'b1, PER_MAX);
        repeat (6) begin
            send_item(OP_ADD, pick_sample(), 1'b0, '0);
            send_item(OP_ADD, pick_sample(), 1'b1, PERIOD_W'($urandom_range(0, PER_MAX)));
        end
        play_frames(60);
        i_in_valid <= 1'b0;

        // drain, then a quiet spell to catch stray results
        w = 0;
        do begin
            @(posedge i_clk);
            w++;
        end while (results_outstanding != 0 && w < DRAIN_LIMIT);
        leftover = (results_outstanding != 0);
        if (leftover)
            $display("%0t: %0d results never arrived", $time, results_outstanding);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && !leftover)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule : overlap_add_fractional_buffer_unit_test
